// ----- src/fpfa_pkg.sv -----
// Shared types and constants of the fixed partition fit allocator.
`default_nettype none

package fpfa_pkg;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_FIT_MODE      = 1'b0;
    localparam logic REG_BLOCKS_IN_USE = 1'b1;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int IDX_F_W = 3;
    localparam int LIMIT_W = 4;
    localparam int CFG_W   = 4;

    localparam logic [LIMIT_W-1:0] BLOCKS_IN_USE_RST = 4'd8;

    // parameter defaults
    localparam int NUM_BLOCKS_DEF = 8;
    localparam int SIZE_BITS_DEF  = 16;
    localparam int ID_BITS_DEF    = 8;

    // scan token moving along the cell chain
    typedef struct packed {
        logic valid;
        logic found;
    } t_tok;

    // commit strobes broadcast to every cell
    typedef struct packed {
        logic load_en;
        logic grant_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/fixed_partition_fit_allocator.sv -----
// Top level: fixed partition table with first-fit and worst-fit allocation.
//
//  Channel  | Direction | Handshake                    | Payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | operation, block_index, sizes, id
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | granted, index, entry fields
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Load and read go from IDLE straight to FIN; allocate passes through SCAN first,
// where the scan token walks the cell chain one cell per cycle.
// One item is in work at a time; the next is taken once the result sits in the output register.
// A stalled output holds the commit of the following item until the register frees.
// Reset (i_rst_n low, synchronous) frees every entry and clears owners; sizes stay unknown.
`default_nettype none

module fixed_partition_fit_allocator #(
    parameter int NUM_BLOCKS    = fpfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS     = fpfa_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS       = fpfa_pkg::ID_BITS_DEF,
    localparam int IN_W         = fpfa_pkg::OP_W + fpfa_pkg::IDX_F_W + 2 * SIZE_BITS + ID_BITS,
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W        = 2 + fpfa_pkg::IDX_F_W + SIZE_BITS + ID_BITS,
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // operation, block_index, block_size, request_size, request_id, zero fill
    input  wire  [IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // granted, chosen_index, entry_size, entry_allocated, entry_owner, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire                         i_cfg_index,
    input  wire  [fpfa_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam int OFS_IDX  = fpfa_pkg::OP_W;
    localparam int OFS_BSZ  = OFS_IDX + fpfa_pkg::IDX_F_W;
    localparam int OFS_NEED = OFS_BSZ + SIZE_BITS;
    localparam int OFS_ID   = OFS_NEED + SIZE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   r_state;
    logic [fpfa_pkg::OP_W-1:0]    r_op;
    logic [fpfa_pkg::IDX_F_W-1:0] r_idx;
    logic [SIZE_BITS-1:0]         r_bsize;
    logic [SIZE_BITS-1:0]         r_need;
    logic [ID_BITS-1:0]           r_id;
    logic                         r_mode;
    logic [fpfa_pkg::LIMIT_W-1:0] r_blocks;
    logic                         r_launch;
    logic                         r_found;
    logic [IDX_W-1:0]             r_pick;
    logic [SIZE_BITS-1:0]         r_pick_size;
    logic                         r_out_valid;
    logic [OUT_TDATA_W-1:0]       r_out;
    logic [OUT_TDATA_W-1:0]       n_out;

    fpfa_pkg::t_tok               w_tok   [NUM_BLOCKS+1];
    logic [IDX_W-1:0]             w_cidx  [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0]         w_csize [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0]         w_size  [NUM_BLOCKS];
    logic                         w_busy  [NUM_BLOCKS];
    logic [ID_BITS-1:0]           w_owner [NUM_BLOCKS];

    fpfa_pkg::t_cell_ctl          w_ctl;
    logic                         w_in_xfer;
    logic                         w_fire;
    logic                         w_idx_ok;
    logic [IDX_W-1:0]             w_rd_idx;
    logic [IDX_W-1:0]             w_sel_idx;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);
    assign w_idx_ok      = (32'(r_idx) < NUM_BLOCKS);
    assign w_rd_idx      = IDX_W'(r_idx);
    assign w_sel_idx     = (r_op == fpfa_pkg::OP_ALLOC) ? r_pick : w_rd_idx;

    always_comb begin
        w_ctl.load_en  = w_fire && (r_op == fpfa_pkg::OP_LOAD) && w_idx_ok;
        w_ctl.grant_en = w_fire && (r_op == fpfa_pkg::OP_ALLOC) && r_found;
    end

    // cell chain: the scan token enters cell 0 and advances one cell per cycle
    assign w_tok[0]   = '{valid: r_launch, found: 1'b0};
    assign w_cidx[0]  = '0;
    assign w_csize[0] = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        fpfa_cell #(
            .CELL_IDX   (g),
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_BITS  (SIZE_BITS),
            .ID_BITS    (ID_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sel_idx   (w_sel_idx),
            .i_load_size (r_bsize),
            .i_grant_id  (r_id),
            .i_need      (r_need),
            .i_worst     (r_mode),
            .i_limit     (r_blocks),
            .i_tok       (w_tok[g]),
            .i_cand_idx  (w_cidx[g]),
            .i_cand_size (w_csize[g]),
            .o_tok       (w_tok[g+1]),
            .o_cand_idx  (w_cidx[g+1]),
            .o_cand_size (w_csize[g+1]),
            .o_size      (w_size[g]),
            .o_busy      (w_busy[g]),
            .o_owner     (w_owner[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_blocks <= fpfa_pkg::BLOCKS_IN_USE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == fpfa_pkg::REG_FIT_MODE) begin
                r_mode <= i_cfg_data[0];
            end else begin
                r_blocks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op    <= s_axis_tdata[OFS_IDX-1:0];
            r_idx   <= s_axis_tdata[OFS_BSZ-1:OFS_IDX];
            r_bsize <= s_axis_tdata[OFS_NEED-1:OFS_BSZ];
            r_need  <= s_axis_tdata[OFS_ID-1:OFS_NEED];
            r_id    <= s_axis_tdata[IN_W-1:OFS_ID];
        end
        if (r_state == ST_SCAN && w_tok[NUM_BLOCKS].valid) begin
            r_found     <= w_tok[NUM_BLOCKS].found;
            r_pick      <= w_cidx[NUM_BLOCKS];
            r_pick_size <= w_csize[NUM_BLOCKS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        if (s_axis_tdata[OFS_IDX-1:0] == fpfa_pkg::OP_ALLOC) begin
                            r_launch <= 1'b1;
                            r_state  <= ST_SCAN;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_tok[NUM_BLOCKS].valid) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result word: granted, index, size, allocated, owner from the low bit up
    always_comb begin
        n_out = '0;
        unique case (r_op)
            fpfa_pkg::OP_LOAD: begin
                n_out[OUT_W-1:0] = {ID_BITS'(0), 1'b0, w_idx_ok ? r_bsize : SIZE_BITS'(0),
                                    r_idx, 1'b0};
            end
            fpfa_pkg::OP_ALLOC: begin
                if (r_found) begin
                    n_out[OUT_W-1:0] = {r_id, 1'b1, r_pick_size,
                                        fpfa_pkg::IDX_F_W'(r_pick), 1'b1};
                end
            end
            fpfa_pkg::OP_READ: begin
                if (w_idx_ok) begin
                    n_out[OUT_W-1:0] = {w_busy[w_rd_idx] ? w_owner[w_rd_idx] : ID_BITS'(0),
                                        w_busy[w_rd_idx], w_size[w_rd_idx], r_idx, 1'b0};
                end else begin
                    n_out[OUT_W-1:0] = {ID_BITS'(0), 1'b0, SIZE_BITS'(0), r_idx, 1'b0};
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[NUM_BLOCKS].valid |-> (r_state == ST_SCAN))
        else $error("scan token left the chain outside a scan");

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.grant_en |-> !w_busy[r_pick])
        else $error("grant commits to a busy partition");

    a_grant_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.grant_en |-> (r_pick_size >= r_need))
        else $error("granted partition smaller than the request");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside the commit state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.load_en || w_ctl.grant_en) |-> !(w_ctl.load_en && w_ctl.grant_en))
        else $error("load and grant committed together");

endmodule

`default_nettype wire

// ----- src/fpfa_cell.sv -----
// One partition entry of the allocator chain, with its stage of the fit scan.
`default_nettype none

module fpfa_cell #(
    parameter int CELL_IDX   = 0,
    parameter int NUM_BLOCKS = fpfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS    = fpfa_pkg::ID_BITS_DEF,
    localparam int IDX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  fpfa_pkg::t_cell_ctl          i_ctl,
    input  wire  [IDX_W-1:0]             i_sel_idx,
    input  wire  [SIZE_BITS-1:0]         i_load_size,
    input  wire  [ID_BITS-1:0]           i_grant_id,
    input  wire  [SIZE_BITS-1:0]         i_need,
    input  wire                          i_worst,
    input  wire  [fpfa_pkg::LIMIT_W-1:0] i_limit,
    input  fpfa_pkg::t_tok               i_tok,
    input  wire  [IDX_W-1:0]             i_cand_idx,
    input  wire  [SIZE_BITS-1:0]         i_cand_size,
    output fpfa_pkg::t_tok               o_tok,
    output logic [IDX_W-1:0]             o_cand_idx,
    output logic [SIZE_BITS-1:0]         o_cand_size,
    output logic [SIZE_BITS-1:0]         o_size,
    output logic                         o_busy,
    output logic [ID_BITS-1:0]           o_owner
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_busy;
    logic [ID_BITS-1:0]   r_owner;
    fpfa_pkg::t_tok       r_tok;
    logic [IDX_W-1:0]     r_cidx;
    logic [SIZE_BITS-1:0] r_csize;

    logic w_me;
    logic w_elig;
    logic w_take;

    assign w_me   = (i_sel_idx == MY_IDX);
    assign w_elig = !r_busy && (r_size >= i_need) && (32'(i_limit) > CELL_IDX);
    // first fit keeps the earliest hit; worst fit replaces on a strictly larger size
    assign w_take = w_elig && (!i_tok.found || (i_worst && (r_size > i_cand_size)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && w_me) begin
            r_size <= i_load_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_owner <= '0;
        end else if (i_ctl.load_en && w_me) begin
            r_busy  <= 1'b0;
            r_owner <= '0;
        end else if (i_ctl.grant_en && w_me) begin
            r_busy  <= 1'b1;
            r_owner <= i_grant_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok.valid <= i_tok.valid;
            r_tok.found <= i_tok.found || w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx  <= w_take ? MY_IDX : i_cand_idx;
        r_csize <= w_take ? r_size : i_cand_size;
    end

    assign o_tok       = r_tok;
    assign o_cand_idx  = r_cidx;
    assign o_cand_size = r_csize;
    assign o_size      = r_size;
    assign o_busy      = r_busy;
    assign o_owner     = r_owner;

endmodule

`default_nettype wire
